// ===== design/bmap_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types for the battery moving average block
package bmap_pkg;

    localparam int WINDOW       = 100;
    localparam int PIN_W        = 12;
    localparam int MV_W         = 13;
    localparam int PCT_W        = 7;
    localparam int PERCENT_SPAN = 100;
    localparam int EMPTY_RESET  = 3700;
    localparam int FULL_RESET   = 4200;
    localparam int MV_MAX       = 8190;

    localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = $clog2(WINDOW * MV_MAX + 1);
    localparam int PROD_W = $clog2(((1 << MV_W) - 1) * PERCENT_SPAN + 1);
    localparam int DIV_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int CNT_W  = $clog2(DIV_W);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_MEAN_DIV,
        S_SCALE,
        S_PCT_DIV,
        S_FINISH
    } t_state;

endpackage

// ===== design/bmap_ram.sv =====
`timescale 1ns / 1ps
// generic single write port ram with registered read
module bmap_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 100,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/battery_moving_average_percent_top.sv =====
`timescale 1ns / 1ps
// Battery moving average and charge percent. Each transaction takes a divider
// sample, doubles it, puts it into a ring of the last WINDOW samples and
// returns the mean over the filled part of the ring plus a charge percent
// mapped linearly between the empty and full registers and clamped to 0..100.
// One shared restoring divider, one quotient bit per cycle, runs twice per
// transaction (mean, then percent). The finished result waits in an output
// register, and the input takes the next transaction only once that result
// has been written there. The sample ring needs no clearing pass: entries
// not yet written read as zero while the fill count is below WINDOW.
module battery_moving_average_percent_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [bmap_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bmap_pkg::MV_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [bmap_pkg::PIN_W-1:0]      i_pin_millivolts,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [bmap_pkg::MV_W-1:0]       o_mean_millivolts,
    output logic [bmap_pkg::PCT_W-1:0]      o_charge_percent
);

    localparam int MV_W   = bmap_pkg::MV_W;
    localparam int POS_W  = bmap_pkg::POS_W;
    localparam int FILL_W = bmap_pkg::FILL_W;
    localparam int SUM_W  = bmap_pkg::SUM_W;
    localparam int PROD_W = bmap_pkg::PROD_W;
    localparam int DIV_W  = bmap_pkg::DIV_W;
    localparam int CNT_W  = bmap_pkg::CNT_W;
    localparam int PCT_W  = bmap_pkg::PCT_W;

    bmap_pkg::t_state r_state, n_state;

    logic [MV_W-1:0]   r_empty, r_full;
    logic [MV_W-1:0]   r_sample, n_sample;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [DIV_W-1:0]  r_quo, n_quo;
    logic [MV_W-1:0]   r_rem, n_rem;
    logic [MV_W-1:0]   r_den, n_den;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [MV_W-1:0]   r_mean, n_mean;
    logic              r_pct_zero, n_pct_zero;
    logic              r_out_valid, n_out_valid;
    logic [MV_W-1:0]   r_out_mean, n_out_mean;
    logic [PCT_W-1:0]  r_out_pct, n_out_pct;

    logic              ram_wr_en;
    logic [MV_W-1:0]   ram_rd_data;
    logic [MV_W-1:0]   old_sample;
    logic [MV_W:0]     trial;
    logic              trial_ge;
    logic [MV_W-1:0]   diff;
    logic [PROD_W-1:0] prod;

    bmap_ram #(
        .WIDTH (MV_W),
        .DEPTH (bmap_pkg::WINDOW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_pos),
        .i_wr_data (r_sample),
        .i_rd_addr (r_pos),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bmap_pkg::S_IDLE;
            r_empty     <= MV_W'(bmap_pkg::EMPTY_RESET);
            r_full      <= MV_W'(bmap_pkg::FULL_RESET);
            r_pos       <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en && i_cfg_index == bmap_pkg::CFG_EMPTY) begin
                r_empty <= i_cfg_data;
            end
            if (i_cfg_wr_en && i_cfg_index == bmap_pkg::CFG_FULL) begin
                r_full <= i_cfg_data;
            end
        end
        r_sample   <= n_sample;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_den      <= n_den;
        r_cnt      <= n_cnt;
        r_mean     <= n_mean;
        r_pct_zero <= n_pct_zero;
        r_out_mean <= n_out_mean;
        r_out_pct  <= n_out_pct;
    end

    always_comb begin
        n_state     = r_state;
        n_sample    = r_sample;
        n_pos       = r_pos;
        n_fill      = r_fill;
        n_sum       = r_sum;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_den       = r_den;
        n_cnt       = r_cnt;
        n_mean      = r_mean;
        n_pct_zero  = r_pct_zero;
        n_out_valid = r_out_valid;
        n_out_mean  = r_out_mean;
        n_out_pct   = r_out_pct;
        ram_wr_en   = 1'b0;
        o_in_ready  = 1'b0;

        // shared restoring divider step
        trial    = {r_rem, r_quo[DIV_W-1]};
        trial_ge = trial >= {1'b0, r_den};

        // slots not yet written read as zero
        old_sample = (r_fill == FILL_W'(bmap_pkg::WINDOW)) ? ram_rd_data : '0;
        diff       = r_quo[MV_W-1:0] - r_empty;
        prod       = PROD_W'(diff) * PROD_W'(bmap_pkg::PERCENT_SPAN);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            bmap_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_sample = {i_pin_millivolts, 1'b0};
                    n_state  = bmap_pkg::S_UPDATE;
                end
            end
            bmap_pkg::S_UPDATE: begin
                ram_wr_en = 1'b1;
                n_sum     = r_sum - SUM_W'(old_sample) + SUM_W'(r_sample);
                if (r_fill != FILL_W'(bmap_pkg::WINDOW)) begin
                    n_fill = r_fill + FILL_W'(1);
                end
                if (r_pos == POS_W'(bmap_pkg::WINDOW - 1)) begin
                    n_pos = '0;
                end else begin
                    n_pos = r_pos + POS_W'(1);
                end
                n_quo   = DIV_W'(n_sum);
                n_den   = MV_W'(n_fill);
                n_rem   = '0;
                n_cnt   = '0;
                n_state = bmap_pkg::S_MEAN_DIV;
            end
            bmap_pkg::S_MEAN_DIV, bmap_pkg::S_PCT_DIV: begin
                n_rem = trial_ge ? MV_W'(trial - {1'b0, r_den}) : MV_W'(trial);
                n_quo = {r_quo[DIV_W-2:0], trial_ge};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    n_state = (r_state == bmap_pkg::S_MEAN_DIV) ?
                              bmap_pkg::S_SCALE : bmap_pkg::S_FINISH;
                end
            end
            bmap_pkg::S_SCALE: begin
                n_mean     = r_quo[MV_W-1:0];
                n_pct_zero = (r_full <= r_empty) || (r_quo[MV_W-1:0] <= r_empty);
                n_quo      = DIV_W'(prod);
                n_den      = r_full - r_empty;
                n_rem      = '0;
                n_cnt      = '0;
                n_state    = bmap_pkg::S_PCT_DIV;
            end
            bmap_pkg::S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_mean  = r_mean;
                    if (r_pct_zero) begin
                        n_out_pct = '0;
                    end else if (r_quo > DIV_W'(bmap_pkg::PERCENT_SPAN)) begin
                        n_out_pct = PCT_W'(bmap_pkg::PERCENT_SPAN);
                    end else begin
                        n_out_pct = r_quo[PCT_W-1:0];
                    end
                    n_state = bmap_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bmap_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_mean_millivolts = r_out_mean;
    assign o_charge_percent  = r_out_pct;

    // ring is written in order, so the write slot equals the fill count until full
    a_pos_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != FILL_W'(bmap_pkg::WINDOW)) |-> (FILL_W'(r_pos) == r_fill))
        else $error("write slot does not match fill count");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(bmap_pkg::WINDOW))
        else $error("fill count beyond window");

    a_pct_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_charge_percent <= PCT_W'(bmap_pkg::PERCENT_SPAN)))
        else $error("charge percent above full scale");

    a_accept_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == bmap_pkg::S_UPDATE))
        else $error("accepted transaction not stored");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_mean_millivolts) && $stable(o_charge_percent)))
        else $error("pending result changed");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for battery_moving_average_percent_top with a window-average scoreboard
module tb_top;

    localparam int WINDOW       = bmap_pkg::WINDOW;
    localparam int MV_W         = bmap_pkg::MV_W;
    localparam int PIN_W        = bmap_pkg::PIN_W;
    localparam int PCT_W        = bmap_pkg::PCT_W;
    localparam int CFG_IDX_W    = bmap_pkg::CFG_IDX_W;
    localparam int PERCENT_SPAN = bmap_pkg::PERCENT_SPAN;
    localparam int EMPTY_RESET  = bmap_pkg::EMPTY_RESET;
    localparam int FULL_RESET   = bmap_pkg::FULL_RESET;

    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES  = 60;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 165;
    localparam int LEVEL_HOLD   = 40;
    localparam int MV_TOP       = (1 << MV_W) - 1;
    localparam int PIN_TOP      = (1 << PIN_W) - 1;

    typedef struct packed {
        logic [MV_W-1:0]  mean_mv;
        logic [PCT_W-1:0] pct;
    } t_reading;

    class charge_scoreboard;
        int unsigned ring [WINDOW];
        int unsigned wr_pos;
        int unsigned filled;
        int unsigned total;
        int unsigned empty_mv;
        int unsigned full_mv;
        t_reading    readings [$];

        function new();
            foreach (ring[k]) ring[k] = 0;
            wr_pos   = 0;
            filled   = 0;
            total    = 0;
            empty_mv = EMPTY_RESET;
            full_mv  = FULL_RESET;
        endfunction

        function void set_levels(int unsigned e, int unsigned f);
            empty_mv = e;
            full_mv  = f;
        endfunction

        function int unsigned pending();
            return readings.size();
        endfunction

        // accepted input transaction: update the window and predict the reading
        function void note_sample(logic [PIN_W-1:0] pin);
            int unsigned sample;
            int unsigned avg;
            int unsigned pct;
            t_reading    want;
            sample = 2 * pin;
            total = total - ring[wr_pos] + sample;
            ring[wr_pos] = sample;
            if (filled < WINDOW) filled++;
            wr_pos = (wr_pos + 1) % WINDOW;
            avg = total / filled;
            pct = 0;
            if (full_mv > empty_mv && avg > empty_mv) begin
                pct = (avg - empty_mv) * PERCENT_SPAN / (full_mv - empty_mv);
                if (pct > PERCENT_SPAN) pct = PERCENT_SPAN;
            end
            want.mean_mv = avg[MV_W-1:0];
            want.pct     = pct[PCT_W-1:0];
            readings.push_back(want);
        endfunction

        // accepted output transaction: compare with the oldest prediction
        function bit check_reading(logic [MV_W-1:0] mean_mv, logic [PCT_W-1:0] pct,
                                   output string msg);
            t_reading want;
            msg = "";
            if (readings.size() == 0) begin
                msg = $sformatf("unexpected result mean %0d percent %0d", mean_mv, pct);
                return 1'b0;
            end
            want = readings.pop_front();
            if (mean_mv !== want.mean_mv)
                msg = $sformatf("mean %0d, expected %0d;", mean_mv, want.mean_mv);
            if (pct !== want.pct)
                msg = {msg, $sformatf(" percent %0d, expected %0d", pct, want.pct)};
            return msg == "";
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = bmap_pkg::CFG_EMPTY;
    logic [MV_W-1:0]    i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [PIN_W-1:0]   i_pin_millivolts = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [MV_W-1:0]    o_mean_millivolts;
    logic [PCT_W-1:0]   o_charge_percent;

    charge_scoreboard sb;
    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  next_gap = 0;
    bit  quiet = 1'b0;

    battery_moving_average_percent_top uut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("** battery_moving_average_percent_top: FAILED **");
            $finish;
        end
    end

    task automatic report(string msg);
        if (mismatch_count < 100) $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    function automatic int draw_wait();
        return quiet ? 0 : int'($urandom_range(0, 4));
    endfunction

    // sample around a battery level, sometimes anywhere in the input range
    function automatic logic [PIN_W-1:0] pick_pin(int lvl);
        int v;
        if ($urandom_range(0, 9) < 2) return PIN_W'($urandom_range(0, PIN_TOP));
        v = lvl + int'($urandom_range(0, 100)) - 50;
        if (v < 0) v = 0;
        if (v > PIN_TOP) v = PIN_TOP;
        return PIN_W'(v);
    endfunction

    task automatic send_sample(int unsigned pin);
        if (next_gap > 0) repeat (next_gap) @(posedge i_clk);
        i_in_valid       <= 1'b1;
        i_pin_millivolts <= PIN_W'(pin);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_sample(PIN_W'(pin));
        next_gap = draw_wait();
        if (next_gap > 0) i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        if (next_gap == 0) i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_levels(int unsigned e, int unsigned f);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= bmap_pkg::CFG_EMPTY;
        i_cfg_data  <= MV_W'(e);
        @(posedge i_clk);
        i_cfg_index <= bmap_pkg::CFG_FULL;
        i_cfg_data  <= MV_W'(f);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_levels(e, f);
    endtask

    initial begin : result_side
        int    stall;
        string msg;
        wait (i_rst_n);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            if (!sb.check_reading(o_mean_millivolts, o_charge_percent, msg)) report(msg);
        end
    end

    initial begin : sample_side
        int unsigned e;
        int unsigned f;
        int          lo;
        int          hi;
        int          lvl;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset levels, window still filling
        send_sample(0);
        send_sample(PIN_TOP);
        send_sample(PIN_TOP);
        send_sample(PIN_TOP);
        send_sample(1850);
        send_sample(2100);
        send_sample(2225);
        send_sample(1850);
        wait_drained();
        write_levels(0, MV_TOP);
        send_sample(PIN_TOP);
        send_sample(0);
        send_sample(2048);
        send_sample(1);
        // full equal to empty, then full below empty
        wait_drained();
        write_levels(4000, 4000);
        send_sample(2000);
        send_sample(2500);
        wait_drained();
        write_levels(MV_TOP, 0);
        send_sample(PIN_TOP);
        send_sample(1);

        lvl = 0;
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                0: begin
                    e = EMPTY_RESET;
                    f = FULL_RESET;
                end
                1: begin
                    e = 0;
                    f = MV_TOP;
                end
                4: begin
                    e = $urandom_range(0, MV_TOP);
                    f = e;
                end
                5: begin
                    f = $urandom_range(0, MV_TOP - 1);
                    e = $urandom_range(f + 1, MV_TOP);
                end
                6: begin
                    e = MV_TOP - 3;
                    f = MV_TOP;
                end
                default: begin
                    e = $urandom_range(0, MV_TOP - 1);
                    f = $urandom_range(e + 1, MV_TOP);
                end
            endcase
            quiet = (p == 3);
            write_levels(e, f);
            lo = int'((e < f) ? e : f) / 2 - 200;
            hi = int'((e < f) ? f : e) / 2 + 200;
            if (lo < 0) lo = 0;
            if (hi > PIN_TOP) hi = PIN_TOP;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % LEVEL_HOLD == 0) lvl = int'($urandom_range(lo, hi));
                send_sample(pick_pin(lvl));
            end
        end
        quiet = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && sb.pending() == 0)
            $display("** battery_moving_average_percent_top: PASSED **");
        else
            $display("** battery_moving_average_percent_top: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
design/bmap_pkg.sv
design/bmap_ram.sv
design/battery_moving_average_percent_top.sv
sim/tb_top.sv
